@@ rtl/core/tqdts_pkg.sv @@
// ----------------------------------------------------------------------------
// tqdts_pkg
// Shared types and constants of the two-queue disk track scheduler: field
// widths, item mode codes, the sequencer state type and the result bundle.
// ----------------------------------------------------------------------------
package tqdts_pkg;

  // Field widths of one request.
  localparam int TRACK_W = 11;
  localparam int TAG_W   = 11;
  localparam int KEY_W   = TRACK_W + TAG_W;

  // Default configuration.
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_NUM_UNITS   = 2;

  // Item modes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_HEAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_POP_HEAD,
    ST_SHIFT,
    ST_DONE
  } seq_state_t;

  // Result of one item, handed from the sequencer to the output register.
  typedef struct packed {
    logic               accepted;
    logic               served_valid;
    logic [TRACK_W-1:0] served_track;
    logic [TAG_W-1:0]   served_tag;
    logic               primary_empty;
  } res_t;

endpackage

@@ rtl/core/tqdts_ram.sv @@
// ----------------------------------------------------------------------------
// tqdts_ram
// Queue entry memory: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module tqdts_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 22
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/tqdts_seq.sv @@
// ----------------------------------------------------------------------------
// tqdts_seq
// Sequencer of the scheduler. It keeps the per-unit queue counts and role
// bits, and steps one shared comparator over the queue memory to place new
// requests in order and to close the gap left by a served head.
// ----------------------------------------------------------------------------
module tqdts_seq #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_UNITS   = 2,
  parameter int ADDR_W      = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic                            in_disk_unit,
  input  logic [tqdts_pkg::TRACK_W-1:0]   in_track,
  input  logic [tqdts_pkg::TAG_W-1:0]     in_tag,
  output logic                            res_valid,
  input  logic                            res_ready,
  output tqdts_pkg::res_t                 res,
  output logic                            mem_we,
  output logic [ADDR_W-1:0]               mem_waddr,
  output logic [tqdts_pkg::KEY_W-1:0]     mem_wdata,
  output logic [ADDR_W-1:0]               mem_raddr,
  input  logic [tqdts_pkg::KEY_W-1:0]     mem_rdata
);

  import tqdts_pkg::*;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int UNIT_W = ADDR_W - 1 - IDX_W;
  localparam logic [CNT_W-1:0] QD_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE    = CNT_W'(1);

  seq_state_t        state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [UNIT_W-1:0] unit_r, unit_nxt;
  logic              unit_ok_r, unit_ok_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              bank_r, bank_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic              acc_r, acc_nxt;
  logic              sv_r, sv_nxt;
  logic [KEY_W-1:0]  served_r, served_nxt;
  logic [CNT_W-1:0]  cnt_r   [NUM_UNITS][2];
  logic [CNT_W-1:0]  cnt_nxt [NUM_UNITS][2];
  logic              sel_r   [NUM_UNITS];
  logic              sel_nxt [NUM_UNITS];

  logic             pri_b;
  logic [CNT_W-1:0] pc;
  logic [CNT_W-1:0] sc;
  logic [CNT_W-1:0] tc;
  logic [CNT_W-1:0] oc;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W-1:0] pos_p1;
  logic [KEY_W-1:0] cmp_a;
  logic [KEY_W-1:0] cmp_b;
  logic             cmp_le;

  // Counts of the addressed unit: primary, secondary, working bank, other bank.
  assign pri_b  = sel_r[unit_r];
  assign pc     = cnt_r[unit_r][pri_b];
  assign sc     = cnt_r[unit_r][~pri_b];
  assign tc     = cnt_r[unit_r][bank_r];
  assign oc     = cnt_r[unit_r][~bank_r];
  assign pos_m1 = pos_r - ONE;
  assign pos_p1 = pos_r + ONE;

  // The shared comparator. For the head check the tag bits are padded so
  // that the key compare reduces to a compare of tracks only.
  always_comb begin
    if (state_r == ST_HEAD) begin
      cmp_a = {mem_rdata[KEY_W-1:TAG_W], {TAG_W{1'b0}}};
      cmp_b = {key_r[KEY_W-1:TAG_W], {TAG_W{1'b1}}};
    end else begin
      cmp_a = key_r;
      cmp_b = mem_rdata;
    end
  end
  assign cmp_le = (cmp_a <= cmp_b);

  // Result bundle, shown while in the done state.
  always_comb begin
    res.accepted      = acc_r;
    res.served_valid  = sv_r;
    res.served_track  = served_r[KEY_W-1:TAG_W];
    res.served_tag    = served_r[TAG_W-1:0];
    res.primary_empty = unit_ok_r ? (pc == '0) : 1'b1;
  end

  // State and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int u = 0; u < NUM_UNITS; u++) begin
        cnt_r[u][0] <= '0;
        cnt_r[u][1] <= '0;
        sel_r[u]    <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    unit_r    <= unit_nxt;
    unit_ok_r <= unit_ok_nxt;
    key_r     <= key_nxt;
    bank_r    <= bank_nxt;
    pos_r     <= pos_nxt;
    acc_r     <= acc_nxt;
    sv_r      <= sv_nxt;
    served_r  <= served_nxt;
  end

  // Next state, memory accesses and count updates.
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    unit_nxt    = unit_r;
    unit_ok_nxt = unit_ok_r;
    key_nxt     = key_r;
    bank_nxt    = bank_r;
    pos_nxt     = pos_r;
    acc_nxt     = acc_r;
    sv_nxt      = sv_r;
    served_nxt  = served_r;
    cnt_nxt     = cnt_r;
    sel_nxt     = sel_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = {unit_r, bank_r, pos_r[IDX_W-1:0]};
    mem_wdata   = key_r;
    mem_raddr   = {unit_r, bank_r, pos_m1[IDX_W-1:0]};

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt    = in_mode;
          unit_nxt    = UNIT_W'(in_disk_unit);
          unit_ok_nxt = (int'(in_disk_unit) < NUM_UNITS);
          key_nxt     = {in_track, in_tag};
          acc_nxt     = 1'b0;
          sv_nxt      = 1'b0;
          served_nxt  = '0;
          state_nxt   = ST_START;
        end
      end

      ST_START: begin
        if (!unit_ok_r) begin
          state_nxt = ST_DONE;
        end else if (mode_r == MODE_INSERT) begin
          if (pc == '0) begin
            bank_nxt  = pri_b;
            pos_nxt   = pc;
            state_nxt = ST_SORT_RD;
          end else if (pc == QD_CNT) begin
            if (sc != QD_CNT) begin
              bank_nxt  = ~pri_b;
              pos_nxt   = sc;
              state_nxt = ST_SORT_RD;
            end else begin
              state_nxt = ST_DONE;
            end
          end else begin
            mem_raddr = {unit_r, pri_b, {IDX_W{1'b0}}};
            state_nxt = ST_HEAD;
          end
        end else begin
          if (pc == '0 && sc == '0) begin
            state_nxt = ST_DONE;
          end else begin
            // An empty primary with a waiting secondary swaps roles first.
            if (pc == '0) begin
              sel_nxt[unit_r] = ~pri_b;
              bank_nxt        = ~pri_b;
              mem_raddr       = {unit_r, ~pri_b, {IDX_W{1'b0}}};
            end else begin
              bank_nxt  = pri_b;
              mem_raddr = {unit_r, pri_b, {IDX_W{1'b0}}};
            end
            state_nxt = ST_POP_HEAD;
          end
        end
      end

      // Primary head is on the read port: pick the queue for the insert.
      ST_HEAD: begin
        if (cmp_le) begin
          bank_nxt  = pri_b;
          pos_nxt   = pc;
          state_nxt = ST_SORT_RD;
        end else if (sc != QD_CNT) begin
          bank_nxt  = ~pri_b;
          pos_nxt   = sc;
          state_nxt = ST_SORT_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      // Fetch the entry below the hole, or drop the key in at the bottom.
      ST_SORT_RD: begin
        if (pos_r == '0) begin
          mem_we                  = 1'b1;
          mem_wdata               = key_r;
          cnt_nxt[unit_r][bank_r] = tc + ONE;
          acc_nxt                 = 1'b1;
          state_nxt               = ST_DONE;
        end else begin
          state_nxt = ST_SORT_CMP;
        end
      end

      // Move the fetched entry up one place, or place the key in the hole.
      ST_SORT_CMP: begin
        mem_we = 1'b1;
        if (cmp_le) begin
          mem_wdata = mem_rdata;
          pos_nxt   = pos_m1;
          state_nxt = ST_SORT_RD;
        end else begin
          mem_wdata               = key_r;
          cnt_nxt[unit_r][bank_r] = tc + ONE;
          acc_nxt                 = 1'b1;
          state_nxt               = ST_DONE;
        end
      end

      // Head entry arrives; start closing the gap from position one.
      ST_POP_HEAD: begin
        served_nxt = mem_rdata;
        sv_nxt     = 1'b1;
        if (tc == ONE) begin
          cnt_nxt[unit_r][bank_r] = tc - ONE;
          if (oc != '0) begin
            sel_nxt[unit_r] = ~bank_r;
          end
          state_nxt = ST_DONE;
        end else begin
          mem_raddr = {unit_r, bank_r, ONE[IDX_W-1:0]};
          pos_nxt   = ONE;
          state_nxt = ST_SHIFT;
        end
      end

      // Each cycle writes one entry down and reads the next one.
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = {unit_r, bank_r, pos_m1[IDX_W-1:0]};
        mem_wdata = mem_rdata;
        if (pos_p1 < tc) begin
          mem_raddr = {unit_r, bank_r, pos_p1[IDX_W-1:0]};
          pos_nxt   = pos_p1;
        end else begin
          cnt_nxt[unit_r][bank_r] = tc - ONE;
          state_nxt               = ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/two_queue_disk_track_scheduler.sv @@
// ----------------------------------------------------------------------------
// two_queue_disk_track_scheduler
// Circular-scan disk request scheduler with a primary and a secondary sorted
// queue per disk unit, built around one queue memory and a small sequencer.
// ----------------------------------------------------------------------------
// Each item is handled alone and the block is not ready until the item's
// result is in the output register. The queue memory has one read and one
// write port and the sequencer has one comparator, so the work is one memory
// step at a time. An insert checks the head of the primary queue when that
// queue is neither empty nor full, moves every stored entry with a larger
// key up a place, and then places the key at the bottom of the queue or
// above a smaller entry. A pop moves the entries behind the head of the
// primary queue down one per cycle. An item for an absent unit, a pop with
// nothing queued or a dropped insert writes nothing to the queue memory.
// While the result waits in the output register the next item is already
// accepted. Queue entries need no clearing after reset; occupancy counts
// reset to zero.
module two_queue_disk_track_scheduler #(
  parameter int QUEUE_DEPTH = tqdts_pkg::DEF_QUEUE_DEPTH,
  parameter int NUM_UNITS   = tqdts_pkg::DEF_NUM_UNITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic                          in_disk_unit,
  input  logic [tqdts_pkg::TRACK_W-1:0] in_track,
  input  logic [tqdts_pkg::TAG_W-1:0]   in_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic                          out_served_valid,
  output logic [tqdts_pkg::TRACK_W-1:0] out_served_track,
  output logic [tqdts_pkg::TAG_W-1:0]   out_served_tag,
  output logic                          out_primary_empty
);

  import tqdts_pkg::*;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int UNIT_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int ADDR_W = UNIT_W + 1 + IDX_W;

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [KEY_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [KEY_W-1:0]  mem_rdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;
  logic load;

  tqdts_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_UNITS   (NUM_UNITS),
    .ADDR_W      (ADDR_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_disk_unit (in_disk_unit),
    .in_track     (in_track),
    .in_tag       (in_tag),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  tqdts_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: takes a finished result whenever it is free or drained.
  assign res_ready     = !out_valid_r || out_ready;
  assign load          = res_valid && res_ready;
  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_res_r.accepted;
  assign out_served_valid  = out_res_r.served_valid;
  assign out_served_track  = out_res_r.served_track;
  assign out_served_tag    = out_res_r.served_tag;
  assign out_primary_empty = out_res_r.primary_empty;

endmodule

@@ rtl/core/tqdts_checker.sv @@
// ----------------------------------------------------------------------------
// tqdts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module tqdts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_accepted,
  input logic                          out_served_valid,
  input logic [tqdts_pkg::TRACK_W-1:0] out_served_track,
  input logic [tqdts_pkg::TAG_W-1:0]   out_served_tag,
  input logic                          out_primary_empty
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted) &&
      $stable(out_served_valid) && $stable(out_served_track) &&
      $stable(out_served_tag) && $stable(out_primary_empty))
    else $error("result item changed while stalled");

  // An item is never both a stored insert and a served pop.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && out_served_valid))
    else $error("result item flags both accepted and served");

  // Nothing served means zero track and tag.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_served_valid |-> out_served_track == '0 && out_served_tag == '0)
    else $error("served fields nonzero without a served request");

  // A stored insert always leaves the primary queue occupied.
  a_insert_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> !out_primary_empty)
    else $error("stored insert reported an empty primary queue");

  // The block is not ready in the cycle after it takes an item.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready right after taking an item");

endmodule

bind two_queue_disk_track_scheduler tqdts_checker u_tqdts_checker (.*);

@@ tb/two_queue_disk_track_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// two_queue_disk_track_scheduler_tb
// Self-checking bench for the two-queue disk track scheduler. A scoreboard
// keeps its own copy of both sorted queues of each unit, works out the answer
// to every accepted item and compares each returned result, field by field,
// in order. Stimulus is a short directed run followed by random fill, drain
// and mixed episodes under four sender/receiver idling phases.
// ----------------------------------------------------------------------------
import tqdts_pkg::*;

// Scoreboard: shadow queues per unit and the answers still to come back.
class service_order_board;
  localparam int DEPTH = DEF_QUEUE_DEPTH;
  localparam int UNITS = DEF_NUM_UNITS;

  // Two banks per unit; prim_bank selects which bank is the primary queue.
  logic [KEY_W-1:0] ent[UNITS][2][DEPTH];
  int               cnt[UNITS][2];
  int               prim_bank[UNITS];
  res_t             due_answers[$];
  int               mismatches;

  function new();
    for (int u = 0; u < UNITS; u++) begin
      cnt[u][0] = 0;
      cnt[u][1] = 0;
      prim_bank[u] = 0;
    end
    mismatches = 0;
  endfunction

  // One line per problem, and every problem is counted.
  task report(string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Insertion sort by {track, tag}; a new key goes ahead of an equal one.
  function void place_key(int u, int b, logic [KEY_W-1:0] key);
    int pos;
    pos = cnt[u][b];
    while (pos > 0 && key <= ent[u][b][pos-1]) begin
      ent[u][b][pos] = ent[u][b][pos-1];
      pos--;
    end
    ent[u][b][pos] = key;
    cnt[u][b]++;
  endfunction

  function int pending();
    return due_answers.size();
  endfunction

  // Apply one accepted item to the shadow queues and queue its answer.
  function void note_request(logic mode, logic unit, logic [TRACK_W-1:0] trk,
                             logic [TAG_W-1:0] tg);
    res_t             r;
    int               u, p, s;
    logic [KEY_W-1:0] key, head;
    r = '0;
    u = int'(unit);
    if (u >= UNITS) begin
      // An absent unit leaves everything alone and reports an empty primary.
      r.primary_empty = 1'b1;
      due_answers.push_back(r);
      return;
    end
    p = prim_bank[u];
    s = 1 - p;
    if (mode == MODE_INSERT) begin
      key = {trk, tg};
      if (cnt[u][p] < DEPTH &&
          (cnt[u][p] == 0 || trk >= ent[u][p][0][KEY_W-1:TAG_W])) begin
        place_key(u, p, key);
        r.accepted = 1'b1;
      end else if (cnt[u][s] < DEPTH) begin
        place_key(u, s, key);
        r.accepted = 1'b1;
      end
    end else begin
      if (cnt[u][p] == 0 && cnt[u][s] != 0) begin
        prim_bank[u] = s;
        p = prim_bank[u];
        s = 1 - p;
      end
      if (cnt[u][p] != 0) begin
        head = ent[u][p][0];
        for (int i = 1; i < cnt[u][p]; i++) ent[u][p][i-1] = ent[u][p][i];
        cnt[u][p]--;
        r.served_valid = 1'b1;
        r.served_track = head[KEY_W-1:TAG_W];
        r.served_tag   = head[TAG_W-1:0];
        // The sweep restarts from the lowest waiting track.
        if (cnt[u][p] == 0 && cnt[u][s] != 0) prim_bank[u] = s;
      end
    end
    r.primary_empty = (cnt[u][prim_bank[u]] == 0);
    due_answers.push_back(r);
  endfunction

  // Compare one returned result with the oldest outstanding answer.
  task check_answer(res_t got);
    res_t exp;
    if (due_answers.size() == 0) begin
      report("result returned with no item outstanding");
      return;
    end
    exp = due_answers.pop_front();
    if (got.accepted !== exp.accepted)
      report($sformatf("accepted got %0b exp %0b", got.accepted, exp.accepted));
    if (got.served_valid !== exp.served_valid)
      report($sformatf("served_valid got %0b exp %0b",
                       got.served_valid, exp.served_valid));
    if (got.served_track !== exp.served_track)
      report($sformatf("served_track got %0d exp %0d",
                       got.served_track, exp.served_track));
    if (got.served_tag !== exp.served_tag)
      report($sformatf("served_tag got %0d exp %0d", got.served_tag, exp.served_tag));
    if (got.primary_empty !== exp.primary_empty)
      report($sformatf("primary_empty got %0b exp %0b",
                       got.primary_empty, exp.primary_empty));
  endtask
endclass

module two_queue_disk_track_scheduler_tb;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 232;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_mode;
  logic               in_disk_unit;
  logic [TRACK_W-1:0] in_track;
  logic [TAG_W-1:0]   in_tag;
  logic               out_valid;
  logic               out_ready;
  logic               out_accepted;
  logic               out_served_valid;
  logic [TRACK_W-1:0] out_served_track;
  logic [TAG_W-1:0]   out_served_tag;
  logic               out_primary_empty;

  service_order_board board;
  int                 sender_idle_pct;
  int                 receiver_stall_pct;
  int                 quiet_cycles;

  two_queue_disk_track_scheduler #(
    .QUEUE_DEPTH(DEF_QUEUE_DEPTH),
    .NUM_UNITS  (DEF_NUM_UNITS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_disk_unit     (in_disk_unit),
    .in_track         (in_track),
    .in_tag           (in_tag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_accepted     (out_accepted),
    .out_served_valid (out_served_valid),
    .out_served_track (out_served_track),
    .out_served_tag   (out_served_tag),
    .out_primary_empty(out_primary_empty)
  );

  // Clock with a period of 4.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: ready decided at each falling edge from the current stall rate.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Result checking at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_answer(res_t'{out_accepted, out_served_valid, out_served_track,
                                out_served_tag, out_primary_empty});
  end

  // Watchdog: too long without any item moving on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one item at a falling edge, with random idle cycles ahead of it,
  // and hold it until accepted. Returns at the next falling edge.
  task automatic drive_item(logic mode, logic unit, logic [TRACK_W-1:0] trk,
                            logic [TAG_W-1:0] tg);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_disk_unit <= unit;
    in_track     <= trk;
    in_tag       <= tg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(mode, unit, trk, tg);
    @(negedge clk);
  endtask

  // Hold the sender off until every outstanding result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Random episodes: fill runs push queues to full and into drops, drain runs
  // empty them and force role swaps, mixed runs interleave both.
  task automatic run_phase(int n_items, int idle, int stall);
    int                 done_items;
    int                 ep_len;
    int                 ins_pct;
    logic               unit;
    logic               mode;
    logic [TRACK_W-1:0] trk;
    logic [TAG_W-1:0]   tg;
    sender_idle_pct    = idle;
    receiver_stall_pct = stall;
    done_items = 0;
    while (done_items < n_items) begin
      unit   = 1'($urandom_range(1));
      ep_len = $urandom_range(8, 40);
      case ($urandom_range(2))
        0: ins_pct = 85;
        1: ins_pct = 15;
        default: ins_pct = 50;
      endcase
      for (int k = 0; k < ep_len && done_items < n_items; k++) begin
        if ($urandom_range(99) < 10) unit = ~unit;
        mode = ($urandom_range(99) < ins_pct) ? MODE_INSERT : MODE_POP;
        // Small values give equal tracks and equal keys; the rest span all bits.
        case ($urandom_range(9))
          0, 1: begin
            trk = TRACK_W'($urandom_range(7));
            tg  = TAG_W'($urandom_range(3));
          end
          2: begin
            trk = $urandom_range(1) ? '1 : '0;
            tg  = $urandom_range(1) ? '1 : '0;
          end
          default: begin
            trk = TRACK_W'($urandom);
            tg  = TAG_W'($urandom);
          end
        endcase
        drive_item(mode, unit, trk, tg);
        done_items++;
      end
    end
    wait_drained();
  endtask

  // Main sequence.
  initial begin
    board              = new();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    quiet_cycles       = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_mode      <= MODE_INSERT;
    in_disk_unit <= 1'b0;
    in_track     <= '0;
    in_tag       <= '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Unit 0: pop with nothing queued, extremes, equal keys, a lower track
    // sent to the secondary queue, and the role swap once the primary runs dry.
    drive_item(MODE_POP,    1'b0, 11'd0,    11'd0);
    drive_item(MODE_INSERT, 1'b0, 11'd0,    11'd0);
    drive_item(MODE_INSERT, 1'b0, 11'd2047, 11'd2047);
    drive_item(MODE_INSERT, 1'b0, 11'd2047, 11'd2047);
    drive_item(MODE_INSERT, 1'b0, 11'd5,    11'd9);
    drive_item(MODE_POP,    1'b0, 11'd2047, 11'd2047);
    drive_item(MODE_INSERT, 1'b0, 11'd1,    11'd3);
    drive_item(MODE_INSERT, 1'b0, 11'd1,    11'd0);
    drive_item(MODE_POP,    1'b0, 11'd0,    11'd0);
    drive_item(MODE_POP,    1'b0, 11'd0,    11'd0);
    drive_item(MODE_POP,    1'b0, 11'd0,    11'd0);
    drive_item(MODE_POP,    1'b0, 11'd0,    11'd0);
    drive_item(MODE_POP,    1'b0, 11'd0,    11'd0);
    drive_item(MODE_POP,    1'b0, 11'd0,    11'd0);
    // Unit 1: alternating bit patterns and a tie on track broken by tag.
    drive_item(MODE_INSERT, 1'b1, 11'd1365, 11'd682);
    drive_item(MODE_INSERT, 1'b1, 11'd1365, 11'd681);
    drive_item(MODE_INSERT, 1'b1, 11'd682,  11'd1365);
    drive_item(MODE_POP,    1'b1, 11'd0,    11'd0);
    drive_item(MODE_POP,    1'b1, 11'd0,    11'd0);
    drive_item(MODE_POP,    1'b1, 11'd0,    11'd0);
    drive_item(MODE_POP,    1'b1, 11'd0,    11'd0);
    wait_drained();

    run_phase(PHASE_ITEMS, 0, 0);
    run_phase(PHASE_ITEMS, 65, 0);
    run_phase(PHASE_ITEMS, 0, 65);
    run_phase(PHASE_ITEMS, 20, 20);

    // Let any late result show up before the verdict.
    repeat (60) @(posedge clk);
    if (board.pending() != 0) board.report("results still outstanding at the end");
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
